// ===== sv/edf_pkg.sv =====
// edf_pkg: shared types, status codes and constants for the deadline scheduler
// no dependencies
package edf_pkg;

  localparam int SlotsDef    = 16;
  localparam int TimeBitsDef = 16;
  localparam logic [15:0] HorizonReset = 16'd100;

  typedef enum logic [2:0] {
    ST_RELEASED = 3'd0,
    ST_FULL     = 3'd1,
    ST_BAD      = 3'd2,
    ST_RAN      = 3'd3,
    ST_IDLE     = 3'd4,
    ST_HORIZON  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_SWEEP,
    FS_EXEC,
    FS_OUT
  } fsm_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] job_id;
    logic [15:0] exec_time;
    logic [15:0] deadline_abs;
    logic [15:0] job_period;
    logic        is_periodic_job;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_job_id;
    logic [3:0]  slot_index;
    logic [15:0] remaining_after;
    logic [15:0] dyn_deadline_out;
    logic        completed;
    logic        missed;
    logic        preempted;
    logic [15:0] time_now;
  } out_res_t;

endpackage

// ===== sv/edf_cell.sv =====
// edf_cell: one job slot plus one registered stage of the running-minimum chain
// depends on edf_pkg
module edf_cell import edf_pkg::*; #(
  parameter int SLOTS     = SlotsDef,
  parameter int TIME_BITS = TimeBitsDef,
  parameter int IDX       = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [TIME_BITS-1:0]     now_i,
  // deadline roll at the start of a tick
  input  logic                     roll_i,
  // write of a new job
  input  logic                     wr_i,
  input  logic [15:0]              wr_job_i,
  input  logic [15:0]              wr_rem_i,
  input  logic [TIME_BITS-1:0]     wr_base_i,
  input  logic [TIME_BITS-1:0]     wr_period_i,
  input  logic                     wr_per_i,
  // execution of one unit on the selected slot
  input  logic                     run_i,
  input  logic                     exclude_i,
  // chain in from lower slot
  input  logic                     bv_i,
  input  logic [$clog2(SLOTS)-1:0] bidx_i,
  input  logic [TIME_BITS-1:0]     bdl_i,
  output logic                     bv_o,
  output logic [$clog2(SLOTS)-1:0] bidx_o,
  output logic [TIME_BITS-1:0]     bdl_o,
  output logic                     valid_o,
  output logic [15:0]              job_o,
  output logic [15:0]              rem_o,
  output logic [TIME_BITS-1:0]     dyn_o,
  output logic [TIME_BITS-1:0]     base_o
);
  localparam int IW = $clog2(SLOTS);
  localparam logic [TIME_BITS-1:0] TMax = {TIME_BITS{1'b1}};

  logic                 valid_r;
  logic [15:0]          job_r, rem_r;
  logic [TIME_BITS-1:0] dyn_r, base_r, period_r;
  logic                 per_r;
  logic [TIME_BITS:0]   roll_sum;
  logic                 take;
  logic                 bv_r;
  logic [IW-1:0]        bidx_r;
  logic [TIME_BITS-1:0] bdl_r;

  // saturating deadline roll
  assign roll_sum = {1'b0, dyn_r} + {1'b0, period_r};

  // chain compare: strictly earlier wins, so ties stay with the lower slot
  assign take = valid_r && !exclude_i && (!bv_i || dyn_r < bdl_i);

  // chain stage register toward the next slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r   <= 1'b0;
      bidx_r <= '0;
      bdl_r  <= '0;
    end else begin
      bv_r   <= bv_i | take;
      bidx_r <= take ? IW'(IDX) : bidx_i;
      bdl_r  <= take ? dyn_r : bdl_i;
    end
  end

  assign bv_o   = bv_r;
  assign bidx_o = bidx_r;
  assign bdl_o  = bdl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_i) begin
      valid_r <= 1'b1;
    end else if (run_i && rem_r <= 16'd1) begin
      valid_r <= 1'b0;
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    if (wr_i) begin
      job_r    <= wr_job_i;
      rem_r    <= wr_rem_i;
      dyn_r    <= wr_base_i;
      base_r   <= wr_base_i;
      period_r <= wr_period_i;
      per_r    <= wr_per_i;
    end else begin
      if (roll_i && valid_r && per_r && now_i >= dyn_r) begin
        dyn_r <= roll_sum[TIME_BITS] ? TMax : roll_sum[TIME_BITS-1:0];
      end
      if (run_i && rem_r != 16'd0) begin
        rem_r <= rem_r - 16'd1;
      end
    end
  end

  assign valid_o = valid_r;
  assign job_o   = job_r;
  assign rem_o   = rem_r;
  assign dyn_o   = dyn_r;
  assign base_o  = base_r;
endmodule

// ===== sv/edf_preemptive_scheduler.sv =====
// edf_preemptive_scheduler: earliest-deadline-first job table, one result per request
// depends on edf_pkg and edf_cell; one request at a time
// release and horizon ticks: the request passes through the sweep, exec and output states
// scheduling ticks: roll, then the sweep waits for the registered chain to settle before exec
// and output; a new request is taken only once the result leaves, so output stalls hold it back
// synchronous active-low reset: time 0, table empty, nothing running, horizon 100
module edf_preemptive_scheduler import edf_pkg::*; #(
  parameter int SLOTS     = SlotsDef,
  parameter int TIME_BITS = TimeBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_res_t    out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] SweepLast = CW'(SLOTS);
  localparam logic [TIME_BITS-1:0] TMax = {TIME_BITS{1'b1}};

  fsm_t state_r, state_nxt;
  in_req_t req_r;
  out_res_t res_r, res_nxt;
  logic [15:0] horizon_r;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [IW-1:0] run_slot_r, run_slot_nxt;
  logic run_valid_r, run_valid_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] free_r, free_nxt;
  logic free_v_r, free_v_nxt;

  logic [SLOTS:0]       cbv;
  logic [IW-1:0]        cbidx [SLOTS+1];
  logic [TIME_BITS-1:0] cbdl  [SLOTS+1];
  logic [SLOTS-1:0]     cvalid, cwr, crun;
  logic [15:0]          cjob [SLOTS];
  logic [15:0]          crem [SLOTS];
  logic [TIME_BITS-1:0] cdyn [SLOTS];
  logic [TIME_BITS-1:0] cbase [SLOTS];

  logic accept, is_tick, hz, rel_bad, roll, do_wr, do_run;
  logic [TIME_BITS:0] base_sum;
  logic [TIME_BITS-1:0] base_val, per_val, dl_abs;
  logic [TIME_BITS:0] fin;
  logic [IW-1:0] pick;
  logic pick_v, pick_pre;

  assign accept  = in_valid && !in_stall;
  assign is_tick = !req_r.req_type;
  assign hz      = {{(32-TIME_BITS){1'b0}}, now_r} >= {16'd0, horizon_r};
  assign rel_bad = req_r.exec_time == 16'd0 ||
                   (req_r.is_periodic_job && req_r.job_period == 16'd0);

  // release deadline, clamped to the time range
  always_comb begin
    per_val = '0;
    dl_abs  = '0;
    for (int b = 0; b < TIME_BITS; b++) begin
      if (b < 16) begin
        per_val[b] = req_r.job_period[b];
        dl_abs[b]  = req_r.deadline_abs[b];
      end
    end
    if (TIME_BITS < 16 && (req_r.deadline_abs >> TIME_BITS) != 16'd0) dl_abs = TMax;
    if (TIME_BITS < 16 && (req_r.job_period >> TIME_BITS) != 16'd0) per_val = TMax;
  end
  assign base_sum = {1'b0, now_r} + {1'b0, per_val};
  assign base_val = req_r.is_periodic_job ?
                    (base_sum[TIME_BITS] ? TMax : base_sum[TIME_BITS-1:0]) : dl_abs;

  assign roll   = state_r == FS_SWEEP && cnt_r == '0 && is_tick && !hz;
  assign do_wr  = state_r == FS_EXEC && !is_tick && !rel_bad && free_v_r;
  assign do_run = state_r == FS_EXEC && is_tick && !hz && pick_v;

  // row of slot cells with the registered minimum chain threaded through
  assign cbv[0]   = 1'b0;
  assign cbidx[0] = '0;
  assign cbdl[0]  = '0;
  generate
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      assign cwr[g]  = do_wr && free_r == IW'(g);
      assign crun[g] = do_run && pick == IW'(g);
      edf_cell #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS), .IDX(g)) u_cell (
        .clk, .rst_n,
        .now_i(now_r), .roll_i(roll),
        .wr_i(cwr[g]), .wr_job_i(req_r.job_id), .wr_rem_i(req_r.exec_time),
        .wr_base_i(base_val), .wr_period_i(per_val), .wr_per_i(req_r.is_periodic_job),
        .run_i(crun[g]),
        .exclude_i(run_valid_r && run_slot_r == IW'(g)),
        .bv_i(cbv[g]), .bidx_i(cbidx[g]), .bdl_i(cbdl[g]),
        .bv_o(cbv[g+1]), .bidx_o(cbidx[g+1]), .bdl_o(cbdl[g+1]),
        .valid_o(cvalid[g]), .job_o(cjob[g]), .rem_o(crem[g]),
        .dyn_o(cdyn[g]), .base_o(cbase[g])
      );
    end
  endgenerate

  // lowest free slot
  always_comb begin
    free_v_nxt = 1'b0;
    free_nxt   = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!cvalid[k]) begin
        free_v_nxt = 1'b1;
        free_nxt   = IW'(k);
      end
    end
  end

  // next state: scheduling ticks wait for the chain to settle after the roll
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_IDLE:  if (accept) state_nxt = FS_SWEEP;
      FS_SWEEP: if (!is_tick || hz || cnt_r == SweepLast) state_nxt = FS_EXEC;
      FS_EXEC:  state_nxt = FS_OUT;
      FS_OUT:   if (!out_stall) state_nxt = FS_IDLE;
      default:  state_nxt = FS_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall  = (state_r != FS_IDLE);
    out_valid = (state_r == FS_OUT);
  end

  // sweep cycle counter
  assign cnt_nxt = (state_r == FS_SWEEP) ? cnt_r + CW'(1) : '0;

  // pick from the settled chain: preempt only on a strictly earlier deadline
  always_comb begin
    pick = run_slot_r;
    pick_v = run_valid_r && cvalid[run_slot_r];
    pick_pre = 1'b0;
    if (pick_v) begin
      if (cbv[SLOTS] && cbdl[SLOTS] < cdyn[run_slot_r]) begin
        pick = cbidx[SLOTS];
        pick_pre = 1'b1;
      end
    end else if (cbv[SLOTS]) begin
      pick = cbidx[SLOTS];
      pick_v = 1'b1;
    end
  end

  // result, time and running slot
  always_comb begin
    res_nxt = res_r;
    now_nxt = now_r;
    run_slot_nxt = run_slot_r;
    run_valid_nxt = run_valid_r;
    fin = {1'b0, now_r} + {{TIME_BITS{1'b0}}, 1'b1};
    if (roll && !cvalid[run_slot_r]) run_valid_nxt = 1'b0;
    if (state_r == FS_EXEC) begin
      res_nxt = '0;
      res_nxt.time_now = 16'(now_r);
      if (!is_tick) begin
        if (rel_bad) res_nxt.status = ST_BAD;
        else if (!free_v_r) res_nxt.status = ST_FULL;
        else begin
          res_nxt.status = ST_RELEASED;
          res_nxt.out_job_id = req_r.job_id;
          res_nxt.slot_index = 4'(free_r);
          res_nxt.remaining_after = req_r.exec_time;
          res_nxt.dyn_deadline_out = 16'(base_val);
        end
      end else if (hz) begin
        res_nxt.status = ST_HORIZON;
      end else begin
        now_nxt = fin[TIME_BITS] ? TMax : fin[TIME_BITS-1:0];
        if (pick_v) begin
          res_nxt.status = ST_RAN;
          res_nxt.out_job_id = cjob[pick];
          res_nxt.slot_index = 4'(pick);
          res_nxt.remaining_after = (crem[pick] != 16'd0) ? crem[pick] - 16'd1 : 16'd0;
          res_nxt.dyn_deadline_out = 16'(cdyn[pick]);
          res_nxt.preempted = pick_pre;
          run_slot_nxt = pick;
          run_valid_nxt = 1'b1;
          if (crem[pick] <= 16'd1) begin
            res_nxt.completed = 1'b1;
            res_nxt.missed = fin > {1'b0, cbase[pick]};
            run_valid_nxt = 1'b0;
          end
        end else begin
          res_nxt.status = ST_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      horizon_r <= HorizonReset;
      now_r <= '0;
      run_slot_r <= '0;
      run_valid_r <= 1'b0;
      cnt_r <= '0;
      free_r <= '0;
      free_v_r <= 1'b0;
      res_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) horizon_r <= cfg_wdata;
      now_r <= now_nxt;
      run_slot_r <= run_slot_nxt;
      run_valid_r <= run_valid_nxt;
      cnt_r <= cnt_nxt;
      free_r <= free_nxt;
      free_v_r <= free_v_nxt;
      res_r <= res_nxt;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
  end

  assign out_data = res_r;
endmodule

// ===== tb/sv/tb_edf_preemptive_scheduler.sv =====
// testbench for edf_preemptive_scheduler: directed and random release/tick requests
// checked against an in-bench deadline scheduler predictor; depends on edf_pkg and the rtl
module tb_edf_preemptive_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import edf_pkg::*;

  localparam int NSLOT = 16;
  localparam logic [15:0] TMAX = 16'hffff;
  localparam int WDOG_LIMIT = 20000;

  // scheduler predictor and expected result store
  class edf_scoreboard;
    logic [15:0] horizon;
    logic [15:0] now;
    bit          valid[NSLOT];
    logic [15:0] job[NSLOT];
    logic [15:0] remaining[NSLOT];
    logic [15:0] dyn_dl[NSLOT];
    logic [15:0] base_dl[NSLOT];
    logic [15:0] period[NSLOT];
    bit          periodic[NSLOT];
    int          run_slot;
    bit          run_valid;
    out_res_t    pending[$];
    int          mismatches;

    function new();
      horizon = HorizonReset;
      now = 0;
      run_slot = 0;
      run_valid = 0;
      mismatches = 0;
      foreach (valid[i]) valid[i] = 0;
    endfunction

    function logic [15:0] sat_add(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = a + b;
      return s[16] ? TMAX : s[15:0];
    endfunction

    function int free_count();
      int n;
      n = 0;
      foreach (valid[i]) if (!valid[i]) n++;
      return n;
    endfunction

    // note an accepted request and queue its result
    function void note_request(in_req_t r);
      out_res_t e;
      int fs;
      int best;
      bit pre;
      int s;
      e = '0;
      e.time_now = now;
      fs = -1;
      best = -1;
      pre = 0;
      if (r.req_type) begin
        if (r.exec_time == 0 || (r.is_periodic_job && r.job_period == 0)) begin
          e.status = ST_BAD;
        end else begin
          for (int i = 0; i < NSLOT; i++)
            if (!valid[i] && fs < 0) fs = i;
          if (fs < 0) begin
            e.status = ST_FULL;
          end else begin
            valid[fs] = 1;
            job[fs] = r.job_id;
            remaining[fs] = r.exec_time;
            base_dl[fs] = r.is_periodic_job ? sat_add(now, r.job_period) : r.deadline_abs;
            dyn_dl[fs] = base_dl[fs];
            period[fs] = r.is_periodic_job ? r.job_period : 16'd0;
            periodic[fs] = r.is_periodic_job;
            e.status = ST_RELEASED;
            e.out_job_id = r.job_id;
            e.slot_index = fs[3:0];
            e.remaining_after = r.exec_time;
            e.dyn_deadline_out = base_dl[fs];
          end
        end
      end else if (now >= horizon) begin
        e.status = ST_HORIZON;
      end else begin
        for (int i = 0; i < NSLOT; i++)
          if (valid[i] && periodic[i] && now >= dyn_dl[i])
            dyn_dl[i] = sat_add(dyn_dl[i], period[i]);
        if (run_valid && !valid[run_slot]) run_valid = 0;
        for (int i = 0; i < NSLOT; i++) begin
          if (!valid[i] || (run_valid && i == run_slot)) continue;
          if (best < 0 || dyn_dl[i] < dyn_dl[best]) best = i;
        end
        if (run_valid) begin
          if (best >= 0 && dyn_dl[best] < dyn_dl[run_slot]) begin
            run_slot = best;
            pre = 1;
          end
        end else if (best >= 0) begin
          run_slot = best;
          run_valid = 1;
        end
        if (run_valid) begin
          s = run_slot;
          if (remaining[s] > 0) remaining[s]--;
          e.status = ST_RAN;
          e.out_job_id = job[s];
          e.slot_index = s[3:0];
          e.remaining_after = remaining[s];
          e.dyn_deadline_out = dyn_dl[s];
          e.preempted = pre;
          if (remaining[s] == 0) begin
            e.completed = 1;
            e.missed = ({1'b0, now} + 17'd1 > {1'b0, base_dl[s]});
            valid[s] = 0;
            run_valid = 0;
          end
        end else begin
          e.status = ST_IDLE;
        end
        now = sat_add(now, 16'd1);
      end
      pending.insert(pending.size(), e);
    endfunction

    // compare a result with the oldest expectation
    function void check_result(out_res_t a);
      out_res_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", a);
        return;
      end
      e = pending.pop_front();
      if (a !== e) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, a);
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_stall;
  out_res_t out_data;
  logic     cfg_we;
  logic [15:0] cfg_wdata;

  edf_scoreboard sb;
  int  idle_pct;
  int  wdog;
  bit  done;

  edf_preemptive_scheduler DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // result side: random stall, check on accept
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  // watchdog on cycles with no accepted request or result
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) wdog <= 0;
    else if (!done) wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // send one request, with random gaps before it
  task automatic send(in_req_t r);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_req_t mk_release(logic [15:0] id, logic [15:0] ex, logic [15:0] dl,
                                         logic [15:0] per, bit isp);
    in_req_t r;
    r.req_type = 1'b1;
    r.job_id = id;
    r.exec_time = ex;
    r.deadline_abs = dl;
    r.job_period = per;
    r.is_periodic_job = isp;
    return r;
  endfunction

  function automatic in_req_t mk_tick();
    in_req_t r;
    r = '0;
    r.job_id = 16'($urandom);
    r.exec_time = 16'($urandom);
    r.deadline_abs = 16'($urandom);
    r.job_period = 16'($urandom);
    r.is_periodic_job = 1'($urandom);
    return r;
  endfunction

  // wait for the block to drain, then write the horizon
  task automatic set_horizon(logic [15:0] h);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.horizon = h;
  endtask

  // random release with mostly small execution times
  function automatic in_req_t rand_release();
    logic [15:0] ex;
    logic [15:0] per;
    logic [15:0] dl;
    int k;
    k = $urandom_range(99);
    ex = (k < 85) ? 16'($urandom_range(1, 6)) : ((k < 92) ? 16'($urandom) : 16'd0);
    per = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 20));
    if ($urandom_range(19) == 0) per = 16'd0;
    dl = ($urandom_range(4) == 0) ? 16'($urandom) : 16'(sb.now + $urandom_range(0, 30));
    return mk_release(16'($urandom), ex, dl, per, 1'($urandom_range(1)));
  endfunction

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    idle_pct = 16;
    wdog = 0;
    done = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle, bad releases, extremes, preemption, full table
    send(mk_tick());
    send(mk_release(16'h0000, 16'd0, 16'd5, 16'd0, 1'b0));
    send(mk_release(16'h1234, 16'd3, 16'd5, 16'd0, 1'b1));
    send(mk_release(16'hffff, 16'd2, 16'hffff, 16'hffff, 1'b0));
    send(mk_tick());
    send(mk_release(16'h0001, 16'd2, 16'd3, 16'd0, 1'b0));
    send(mk_tick());
    send(mk_release(16'h0002, 16'd4, 16'd0, 16'd2, 1'b1));
    send(mk_release(16'h0003, 16'hffff, 16'd0, 16'hffff, 1'b1));
    repeat (4) send(mk_tick());
    for (int i = 0; i < 14; i++) send(mk_release(16'(i), 16'd1, 16'd50, 16'd0, 1'b0));
    repeat (30) send(mk_tick());

    // horizon extremes
    set_horizon(16'd0);
    send(mk_tick());
    send(mk_release(16'h00aa, 16'd1, 16'd0, 16'd0, 1'b0));
    set_horizon(16'hffff);

    // random phases under several horizons, one with no idling
    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph == 2) ? 0 : 16;
      if (ph == 3) set_horizon(16'd1);
      if (ph == 4) set_horizon(16'($urandom_range(sb.now + 50, sb.now + 250)));
      if (ph == 5) set_horizon(16'hffff);
      for (int n = 0; n < 210; n++) begin
        if ($urandom_range(99) < 45 && sb.free_count() > 0 || $urandom_range(99) < 5)
          send(rand_release());
        else
          send(mk_tick());
      end
      // sender holds off until the block has drained
      if (ph == 1) while (sb.pending.size() != 0) @(posedge clk);
    end

    // periodic release with a near-maximum period, then ticks
    set_horizon(16'hffff);
    send(mk_release(16'h0bad, 16'd2, 16'd0, 16'hfff0, 1'b1));
    repeat (20) send(mk_tick());

    while (sb.pending.size() != 0) @(posedge clk);
    done = 1;
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
